[rtl/core/square_matrix_add_and_multiply_defines.svh]
`ifndef SQUARE_MATRIX_ADD_AND_MULTIPLY_DEFINES_SVH
`define SQUARE_MATRIX_ADD_AND_MULTIPLY_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SQM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sqm: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define SQM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sqm: next-cycle check failed");

`endif

[rtl/core/sqm_pkg.sv]
`timescale 1ns / 1ps

package sqm_pkg;

    localparam int MAX_DIM = 8;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int DIM_W   = 4;
    localparam int ELEM_W  = 16;
    localparam int SUM_W   = 17;
    localparam int MUL_W   = 2 * ELEM_W;
    localparam int PROD_W  = 35;
    localparam int FUNC_W  = 2;

    localparam int IN_TDATA_W   = 24;
    localparam int OUT_FIELDS_W = 2 * IDX_W + SUM_W + PROD_W;
    localparam int OUT_TDATA_W  = 64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_A    = 2'd0,
        FUNC_WR_B    = 2'd1,
        FUNC_COMPUTE = 2'd2,
        FUNC_NOP     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_ISSUE
    } t_state;

    // Tag travelling alongside each pair of memory reads
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             lastk;
        logic             cap_a;
        logic             cap_b;
        logic             last_res;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    typedef struct packed {
        logic pipe_empty;
        logic out_free;
        logic out_load;
    } t_mac_stat;

endpackage

[rtl/core/sqm_ram.sv]
`timescale 1ns / 1ps

module sqm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/sqm_seq.sv]
`timescale 1ns / 1ps

module sqm_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [sqm_pkg::DIM_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    input  sqm_pkg::t_func            i_func,
    input  sqm_pkg::t_mac_stat        i_stat,
    output logic                      o_in_ready,
    output sqm_pkg::t_tag             o_tag,
    output logic [sqm_pkg::ADDR_W-1:0] o_a_addr,
    output logic [sqm_pkg::ADDR_W-1:0] o_b_addr
);
    import sqm_pkg::*;

    t_state           r_state, n_state;
    logic [DIM_W-1:0] r_dim;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] w_dlast;
    logic             w_start;
    logic             w_klast;
    logic             w_elast;

    // Clamp dim to the store size
    always_comb begin
        if (r_dim > DIM_W'(MAX_DIM)) begin
            w_dlast = IDX_W'(MAX_DIM - 1);
        end else begin
            w_dlast = IDX_W'(r_dim - DIM_W'(1));
        end
    end

    assign w_start = i_in_valid && (i_func == FUNC_COMPUTE) && (r_dim != '0);
    assign w_klast = (r_k == w_dlast);
    assign w_elast = (r_i == w_dlast) && (r_j == w_dlast);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_stat.pipe_empty && i_stat.out_free) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (w_klast) begin
                    n_state = w_elast ? ST_IDLE : ST_WAIT;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                end
            end
            ST_ISSUE: begin
                if (w_klast) begin
                    n_k = '0;
                    if (r_j == w_dlast) begin
                        n_j = '0;
                        n_i = r_i + IDX_W'(1);
                    end else begin
                        n_j = r_j + IDX_W'(1);
                    end
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        o_tag.valid    = (r_state == ST_ISSUE);
        o_tag.first    = (r_k == '0);
        o_tag.lastk    = w_klast;
        o_tag.cap_a    = (r_k == r_j);
        o_tag.cap_b    = (r_k == r_i);
        o_tag.last_res = w_elast;
        o_tag.row      = r_i;
        o_tag.col      = r_j;
        o_a_addr       = {r_i, r_k};
        o_b_addr       = {r_k, r_j};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dim   <= DIM_W'(MAX_DIM);
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            if (i_cfg_we) begin
                r_dim <= i_cfg_wdata;
            end
        end
    end

endmodule

[rtl/core/sqm_mac.sv]
`timescale 1ns / 1ps

module sqm_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sqm_pkg::t_tag                     i_tag,
    input  logic signed [sqm_pkg::ELEM_W-1:0] i_a_data,
    input  logic signed [sqm_pkg::ELEM_W-1:0] i_b_data,
    input  logic                              i_out_ready,
    output sqm_pkg::t_mac_stat                o_stat,
    output logic                              o_out_valid,
    output logic [sqm_pkg::IDX_W-1:0]         o_row,
    output logic [sqm_pkg::IDX_W-1:0]         o_col,
    output logic signed [sqm_pkg::SUM_W-1:0]  o_sum,
    output logic signed [sqm_pkg::PROD_W-1:0] o_prod,
    output logic                              o_last
);
    import sqm_pkg::*;

    t_tag                     r_s1, r_s2;
    logic signed [MUL_W-1:0]  r_mul, n_mul;
    logic signed [ELEM_W-1:0] r_a_ij, r_b_ij;
    logic signed [PROD_W-1:0] r_acc, n_acc;
    logic signed [SUM_W-1:0]  n_sum;
    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_row, r_out_col;
    logic signed [SUM_W-1:0]  r_out_sum;
    logic signed [PROD_W-1:0] r_out_prod;
    logic                     r_out_last;
    logic                     w_load;

    assign n_mul  = i_a_data * i_b_data;
    assign n_acc  = (r_s2.first ? PROD_W'(0) : r_acc) + PROD_W'(r_mul);
    assign n_sum  = SUM_W'(r_a_ij) + SUM_W'(r_b_ij);
    assign w_load = r_s2.valid && r_s2.lastk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1 <= i_tag;
            r_s2 <= r_s1;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= n_mul;
        // Pick A[i][j] and B[i][j] off the product reads as they pass
        if (r_s1.valid && r_s1.cap_a) begin
            r_a_ij <= i_a_data;
        end
        if (r_s1.valid && r_s1.cap_b) begin
            r_b_ij <= i_b_data;
        end
        if (r_s2.valid) begin
            r_acc <= n_acc;
        end
        if (w_load) begin
            r_out_row  <= r_s2.row;
            r_out_col  <= r_s2.col;
            r_out_sum  <= n_sum;
            r_out_prod <= n_acc;
            r_out_last <= r_s2.last_res;
        end
    end

    assign o_stat.pipe_empty = !r_s1.valid && !r_s2.valid;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.out_load   = w_load;
    assign o_out_valid       = r_out_valid;
    assign o_row             = r_out_row;
    assign o_col             = r_out_col;
    assign o_sum             = r_out_sum;
    assign o_prod            = r_out_prod;
    assign o_last            = r_out_last;

endmodule

[rtl/core/square_matrix_add_and_multiply.sv]
`timescale 1ns / 1ps
`include "square_matrix_add_and_multiply_defines.svh"

// Square matrix add and multiply. Element writes (tuser 0 for A, 1 for B)
// produce nothing. A compute word (tuser 2) emits dim*dim results in
// row-major order, each with row, column, A+B and A*B, tlast on the final
// one; tuser 3 is dropped. For each result the reads run first, one A and one
// B element per cycle from the single read port of each store; then the final
// pair passes the read and multiply registers into the accumulator, and the
// pipeline is seen empty before the next result starts. A result still waiting
// on the output holds back the next one. The input side stays not ready until
// the reads for the final result have been issued. dim is written through
// i_cfg_we / i_cfg_wdata; the user must write it only while idle, which the
// block does not enforce. 0 makes a compute word produce nothing, and values
// above 8 act as 8. Store entries read before they are written return
// arbitrary data.
module square_matrix_add_and_multiply (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sqm_pkg::DIM_W-1:0]           i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // row [2:0], col [5:3], value [21:6], zero [23:22]
    input  logic [sqm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // func [1:0]
    input  logic [sqm_pkg::FUNC_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_row [2:0], out_col [5:3], sum [22:6], product [57:23], zero [63:58]
    output logic [sqm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);
    import sqm_pkg::*;

    t_tag                     w_tag;
    t_mac_stat                w_stat;
    t_func                    w_func;
    logic [ADDR_W-1:0]        w_a_addr, w_b_addr, w_waddr;
    logic signed [ELEM_W-1:0] w_a_data, w_b_data;
    logic                     w_in_acc;
    logic                     w_we_a, w_we_b;
    logic [IDX_W-1:0]         w_row, w_col;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [PROD_W-1:0] w_prod;

    assign w_func   = t_func'(s_axis_tuser);
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_we_a   = w_in_acc && (w_func == FUNC_WR_A);
    assign w_we_b   = w_in_acc && (w_func == FUNC_WR_B);
    assign w_waddr  = {s_axis_tdata[IDX_W-1:0], s_axis_tdata[2*IDX_W-1:IDX_W]};

    sqm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_func      (w_func),
        .i_stat      (w_stat),
        .o_in_ready  (s_axis_tready),
        .o_tag       (w_tag),
        .o_a_addr    (w_a_addr),
        .o_b_addr    (w_b_addr)
    );

    sqm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (s_axis_tdata[2*IDX_W+ELEM_W-1:2*IDX_W]),
        .i_raddr (w_a_addr),
        .o_rdata (w_a_data)
    );

    sqm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (s_axis_tdata[2*IDX_W+ELEM_W-1:2*IDX_W]),
        .i_raddr (w_b_addr),
        .o_rdata (w_b_data)
    );

    sqm_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (w_tag),
        .i_a_data    (w_a_data),
        .i_b_data    (w_b_data),
        .i_out_ready (m_axis_tready),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .o_row       (w_row),
        .o_col       (w_col),
        .o_sum       (w_sum),
        .o_prod      (w_prod),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, w_prod, w_sum, w_col, w_row};

    // A new result never lands on one still waiting to be taken
    `SQM_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !w_stat.out_load)
    // Store reads run only while input words are held off
    `SQM_ASSERT_IMP(a_read_blocks_input, i_clk, i_rst_n, w_tag.valid, !s_axis_tready)
    // After the final result of a run, the output goes quiet
    `SQM_ASSERT_NXT(a_gap_after_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)

endmodule
